### design/display_capture_blend_macros.svh
// Assertion macros used by the display capture blend top level.
// Each macro expects signals named clock and reset in the including scope.
`ifndef DISPLAY_CAPTURE_BLEND_MACROS_SVH
`define DISPLAY_CAPTURE_BLEND_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/dcb_pkg.sv
// Shared types and constants of the display capture blend block.
// No dependencies; the other RTL modules all import this package.
package dcb_pkg;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address is four times the index).
   localparam logic [2:0] REG_CAPTURE_SIZE     = 3'd0;
   localparam logic [2:0] REG_DEST_BANK        = 3'd1;
   localparam logic [2:0] REG_DEST_OFFSET      = 3'd2;
   localparam logic [2:0] REG_CAPTURE_MODE     = 3'd3;
   localparam logic [2:0] REG_WEIGHT_A         = 3'd4;
   localparam logic [2:0] REG_WEIGHT_B         = 3'd5;
   localparam logic [2:0] REG_BANK_MAPPED_MASK = 3'd6;

   // Capture modes; both remaining codes select the weighted blend.
   localparam logic [1:0] MODE_SOURCE_A = 2'd0;
   localparam logic [1:0] MODE_SOURCE_B = 2'd1;

   // Arithmetic constants.
   localparam logic [4:0] WEIGHT_MAX   = 5'd16;
   localparam logic [4:0] CHAN_MAX     = 5'h1F;
   localparam logic [9:0] BLEND_ROUND  = 10'd8;
   localparam int         BASE_W       = 17;
   localparam int         DIRTY_NUM_W  = 18;
   localparam int         DIRTY_W      = 9;

   typedef struct packed {
      logic [1:0] capture_size;
      logic [1:0] dest_bank;
      logic [1:0] dest_offset;
      logic [1:0] capture_mode;
      logic [4:0] weight_a;
      logic [4:0] weight_b;
      logic [3:0] bank_mapped_mask;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  line_index;
      logic [7:0]  column_index;
      logic [31:0] pixel_a;
      logic [15:0] pixel_b;
      logic        b_present;
   } req_type;

   typedef struct packed {
      logic               write_enable;
      logic [1:0]         write_bank;
      logic [15:0]        write_addr;
      logic [15:0]        write_data;
      logic [DIRTY_W-1:0] dirty_block;
   } rsp_type;

endpackage

### design/dcb_csr.sv
// APB-style configuration register file of the display capture blend block.
// Depends on dcb_pkg for register indexes and the configuration struct.
module dcb_csr import dcb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_transfer;

   assign pready      = 1'b1;
   assign reg_index   = paddr[CSR_ADDR_W-1:2];
   assign wr_transfer = psel && penable && pwrite;
   assign cfg         = cfg_ff;

   // Register write decode; writes beyond the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_transfer) begin
         case (reg_index)
            REG_CAPTURE_SIZE:     cfg_in.capture_size     = pwdata[1:0];
            REG_DEST_BANK:        cfg_in.dest_bank        = pwdata[1:0];
            REG_DEST_OFFSET:      cfg_in.dest_offset      = pwdata[1:0];
            REG_CAPTURE_MODE:     cfg_in.capture_mode     = pwdata[1:0];
            REG_WEIGHT_A:         cfg_in.weight_a         = pwdata[4:0];
            REG_WEIGHT_B:         cfg_in.weight_b         = pwdata[4:0];
            REG_BANK_MAPPED_MASK: cfg_in.bank_mapped_mask = pwdata[3:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // All registers reset to zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux returns the addressed register, zero extended.
   always_comb begin
      case (reg_index)
         REG_CAPTURE_SIZE:     prdata = CSR_DATA_W'(cfg_ff.capture_size);
         REG_DEST_BANK:        prdata = CSR_DATA_W'(cfg_ff.dest_bank);
         REG_DEST_OFFSET:      prdata = CSR_DATA_W'(cfg_ff.dest_offset);
         REG_CAPTURE_MODE:     prdata = CSR_DATA_W'(cfg_ff.capture_mode);
         REG_WEIGHT_A:         prdata = CSR_DATA_W'(cfg_ff.weight_a);
         REG_WEIGHT_B:         prdata = CSR_DATA_W'(cfg_ff.weight_b);
         REG_BANK_MAPPED_MASK: prdata = CSR_DATA_W'(cfg_ff.bank_mapped_mask);
         default:              prdata = '0;
      endcase
   end

endmodule

### design/dcb_pixel.sv
// Per-pixel datapath: window check, address, dirty block and color capture.
// Purely combinational; depends on dcb_pkg for the payload and config types.
module dcb_pixel import dcb_pkg::*; #(
   parameter int DIRTY_GRANULE = 512
) (
   input  cfg_type cfg,
   input  req_type pix,
   output rsp_type result
);

   // Division by the granule is done as a multiply by a rounded-up reciprocal,
   // which is exact for every numerator below two to the DIRTY_NUM_W.
   localparam int GranLog    = $clog2(DIRTY_GRANULE);
   localparam int RecipShift = DIRTY_NUM_W + GranLog;
   localparam longint unsigned RecipWide =
      ((64'd1 << RecipShift) + DIRTY_GRANULE - 1) / DIRTY_GRANULE;
   localparam logic [DIRTY_NUM_W:0] Recip = (DIRTY_NUM_W + 1)'(RecipWide);
   localparam int ProdW = 2 * DIRTY_NUM_W + 1;

   // One blended channel: weighted sum, rounding, saturation.
   function automatic logic [4:0] blend_chan(input logic [4:0] ca, input logic [4:0] cb,
                                            input logic [4:0] wa, input logic [4:0] wb);
      logic [9:0] sum;
      logic [5:0] shr;
      sum = 10'(ca) * 10'(wa) + 10'(cb) * 10'(wb) + BLEND_ROUND;
      shr = sum[9:4];
      return (shr > 6'(CHAN_MAX)) ? CHAN_MAX : shr[4:0];
   endfunction

   logic              in_window;
   logic              mapped;
   logic [BASE_W-1:0] line_off;
   logic [BASE_W-1:0] base;
   logic [BASE_W-1:0] addr_full;
   logic [ProdW-1:0]  dirty_prod;
   logic [4:0]        ra, ga, ba, rb, gb, bb;
   logic              aa, ab;
   logic [4:0]        ca_r, ca_g, ca_b, cb_r, cb_g, cb_b;
   logic [4:0]        wa, wb;
   logic              blend_alpha;
   logic [15:0]       data;

   // Capture window and bank mapping.
   always_comb begin
      if (cfg.capture_size == 2'd0) begin
         in_window = !pix.line_index[7] && !pix.column_index[7];
         line_off  = {2'b00, pix.line_index, 7'd0};
      end else begin
         in_window = pix.line_index[7:6] < cfg.capture_size;
         line_off  = {1'b0, pix.line_index, 8'd0};
      end
   end
   assign mapped = cfg.bank_mapped_mask[cfg.dest_bank];

   // Line start address, write address and dirty block index.
   assign base       = BASE_W'({cfg.dest_offset, 14'd0}) + line_off;
   assign addr_full  = base + BASE_W'(pix.column_index);
   assign dirty_prod = ProdW'({base, 1'b0}) * ProdW'(Recip);

   // Source unpacking; in a blend an absent or transparent source adds nothing.
   assign ra = pix.pixel_a[5:1];
   assign ga = pix.pixel_a[13:9];
   assign ba = pix.pixel_a[21:17];
   assign aa = pix.pixel_a[31:24] != 8'd0;
   assign rb = pix.pixel_b[4:0];
   assign gb = pix.pixel_b[9:5];
   assign bb = pix.pixel_b[14:10];
   assign ab = pix.b_present && pix.pixel_b[15];

   assign ca_r = aa ? ra : 5'd0;
   assign ca_g = aa ? ga : 5'd0;
   assign ca_b = aa ? ba : 5'd0;
   assign cb_r = ab ? rb : 5'd0;
   assign cb_g = ab ? gb : 5'd0;
   assign cb_b = ab ? bb : 5'd0;

   assign wa = (cfg.weight_a > WEIGHT_MAX) ? WEIGHT_MAX : cfg.weight_a;
   assign wb = (cfg.weight_b > WEIGHT_MAX) ? WEIGHT_MAX : cfg.weight_b;
   assign blend_alpha = ((wa != 5'd0) && aa) || ((wb != 5'd0) && ab);

   // Color selection by capture mode.
   always_comb begin
      case (cfg.capture_mode)
         MODE_SOURCE_A: data = {aa, ba, ga, ra};
         MODE_SOURCE_B: data = pix.b_present ? pix.pixel_b : 16'd0;
         default: data = {blend_alpha, blend_chan(ca_b, cb_b, wa, wb),
                          blend_chan(ca_g, cb_g, wa, wb), blend_chan(ca_r, cb_r, wa, wb)};
      endcase
   end

   // A rejected pixel gives an all-zero result.
   always_comb begin
      result = '0;
      if (in_window && mapped) begin
         result.write_enable = 1'b1;
         result.write_bank   = cfg.dest_bank;
         result.write_addr   = addr_full[15:0];
         result.write_data   = data;
         result.dirty_block  = DIRTY_W'(dirty_prod >> RecipShift);
      end
   end

endmodule

### design/display_capture_blend.sv
// Top level of the display capture blend block: configuration port,
// input and result registers around the per-pixel datapath.
// Depends on dcb_pkg, dcb_csr, dcb_pixel and display_capture_blend_macros.svh.
//
// Usage:
//  - Pixels enter on the req_ channel (valid/ready); each transfer carries one
//    req_type item. Every item yields exactly one rsp_type item on rsp_.
//  - A result is registered first in the input register and then in the result
//    register, where it is presented on rsp_valid; a stall on rsp_ready holds it
//    there until it transfers out.
//  - One pixel per clock unless stalled; the datapath between the two registers
//    is a single pass of window, address, reciprocal multiply and blend logic.
//  - When the receiver stalls, the result register holds its item and the input
//    register can still take one more pixel; req_ready drops only when both
//    registers are full and rsp_ready is low.
//  - Configuration registers are written over the APB-style port (pready is
//    always high) and must only change while no pixel is in flight.
//  - Synchronous reset empties both registers and clears all configuration.
`include "display_capture_blend_macros.svh"

module display_capture_blend import dcb_pkg::*; #(
   parameter int DIRTY_GRANULE = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   rsp_type result;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    out_adv;
   logic    req_transfer;

   logic    s1_stalled;
   logic    rsp_reject;
   logic    rsp_write;
   logic    rsp_fields_zero;
   logic    bank_is_mapped;

   dcb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dcb_pixel #(
      .DIRTY_GRANULE (DIRTY_GRANULE)
   ) u_pixel (
      .cfg    (cfg),
      .pix    (s1_data_ff),
      .result (result)
   );

   // Flow control: the result register advances when empty or taken.
   assign out_adv      = !out_valid_ff || rsp_ready;
   assign req_ready    = !s1_valid_ff || out_adv;
   assign req_transfer = req_valid && req_ready;

   always_comb begin
      if (req_transfer) begin
         s1_valid_in = 1'b1;
      end else if (out_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_data_ff <= req_data;
      end
      if (out_adv && s1_valid_ff) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Terms used by the checks below.
   assign s1_stalled      = s1_valid_ff && !out_adv;
   assign rsp_reject      = rsp_valid && !rsp_data.write_enable;
   assign rsp_write       = rsp_valid && rsp_data.write_enable;
   assign rsp_fields_zero = (rsp_data.write_bank == 2'd0) && (rsp_data.write_addr == 16'd0) &&
                            (rsp_data.write_data == 16'd0) && (rsp_data.dirty_block == '0);
   assign bank_is_mapped  = cfg.bank_mapped_mask[rsp_data.write_bank];

   // A held input item must not change while the result side is stalled.
   `DCB_ASSERT_NEXT(a_s1_hold, s1_stalled, s1_valid_ff && $stable(s1_data_ff), "held item lost")
   // A new item may enter a full input register only when that item moves on.
   `DCB_ASSERT_NOW(a_s1_no_overwrite, req_transfer && s1_valid_ff, out_adv, "item overwritten")
   // A rejected pixel carries an all-zero result.
   `DCB_ASSERT_NOW(a_zero_on_reject, rsp_reject, rsp_fields_zero, "rejected result not zero")
   // A write only targets a mapped bank.
   `DCB_ASSERT_NOW(a_mapped_bank, rsp_write, bank_is_mapped, "write to unmapped bank")

endmodule

### dv/tb_top.sv
// Self-checking testbench for the display capture blend block.
// Depends on dcb_pkg and the display_capture_blend RTL; drives pixels, checks every write.
// The predicted write for each pixel transfer is compared field by field with the result.
module tb_top;
   import dcb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRTY_GRANULE = 512;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PIXELS = 100;
   localparam time RUN_LIMIT = 4ms;

   // Both remaining mode codes select the weighted blend.
   localparam logic [1:0] MODE_BLEND     = 2'd2;
   localparam logic [1:0] MODE_BLEND_ALT = 2'd3;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Configuration as the block should currently hold it.
   cfg_type     shadow_cfg = '0;
   rsp_type     expected_writes[$];
   int unsigned sent_count = 0;
   int unsigned received_count = 0;
   int unsigned mismatch_count = 0;

   // Receiver behavior, set by the tests.
   bit sink_throttle = 1'b0;
   bit long_hold = 1'b0;

   display_capture_blend #(
      .DIRTY_GRANULE(DIRTY_GRANULE)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(RUN_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // Computes the capture write that one pixel produces under a given configuration.
   function automatic rsp_type predict_capture(cfg_type c, req_type p);
      rsp_type     w;
      int unsigned width, height, base, wa, wb, aa, ab, mix;
      int unsigned ca[3];
      int unsigned cb[3];
      logic [4:0]  chan[3];
      logic        alpha;
      logic [15:0] data;
      w = '0;
      if (c.capture_size == 2'd0) begin
         width = 128;
         height = 128;
      end else begin
         width = 256;
         height = 64 * 32'(c.capture_size);
      end
      if (32'(p.line_index) >= height || 32'(p.column_index) >= width) return w;
      if (!c.bank_mapped_mask[c.dest_bank]) return w;

      base = (32'(c.dest_offset) << 14) + 32'(p.line_index) * width;

      ca[0] = 32'(p.pixel_a[5:1]);
      ca[1] = 32'(p.pixel_a[13:9]);
      ca[2] = 32'(p.pixel_a[21:17]);
      aa = (p.pixel_a[31:24] != 8'd0) ? 1 : 0;
      if (p.b_present) begin
         cb[0] = 32'(p.pixel_b[4:0]);
         cb[1] = 32'(p.pixel_b[9:5]);
         cb[2] = 32'(p.pixel_b[14:10]);
         ab = 32'(p.pixel_b[15]);
      end else begin
         cb = '{0, 0, 0};
         ab = 0;
      end

      case (c.capture_mode)
         MODE_SOURCE_A: data = {aa[0], 5'(ca[2]), 5'(ca[1]), 5'(ca[0])};
         MODE_SOURCE_B: data = p.b_present ? p.pixel_b : 16'd0;
         default: begin
            wa = (c.weight_a > WEIGHT_MAX) ? 32'(WEIGHT_MAX) : 32'(c.weight_a);
            wb = (c.weight_b > WEIGHT_MAX) ? 32'(WEIGHT_MAX) : 32'(c.weight_b);
            for (int i = 0; i < 3; i++) begin
               mix = (ca[i] * aa * wa + cb[i] * ab * wb + 32'(BLEND_ROUND)) >> 4;
               chan[i] = (mix > 32'(CHAN_MAX)) ? CHAN_MAX : 5'(mix);
            end
            alpha = (wa > 0 && aa != 0) || (wb > 0 && ab != 0);
            data = {alpha, chan[2], chan[1], chan[0]};
         end
      endcase

      w.write_enable = 1'b1;
      w.write_bank   = c.dest_bank;
      w.write_addr   = 16'(base + 32'(p.column_index));
      w.write_data   = data;
      w.dirty_block  = DIRTY_W'((base * 2) / DIRTY_GRANULE);
      return w;
   endfunction

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   // Scoreboard: predicts on each pixel transfer and checks each result transfer.
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            received_count++;
            if (expected_writes.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none actual %0h", $time, rsp_data);
            end else begin
               want = expected_writes.pop_front();
               compare_field("write_enable", 32'(want.write_enable),
                             32'(rsp_data.write_enable));
               compare_field("write_bank", 32'(want.write_bank), 32'(rsp_data.write_bank));
               compare_field("write_addr", 32'(want.write_addr), 32'(rsp_data.write_addr));
               compare_field("write_data", 32'(want.write_data), 32'(rsp_data.write_data));
               compare_field("dirty_block", 32'(want.dirty_block),
                             32'(rsp_data.dirty_block));
            end
         end
         if (req_valid && req_ready)
            expected_writes.push_back(predict_capture(shadow_cfg, req_data));
      end
   end

   // Receiver: ready always, a random on/off pattern, or one long hold-off on request.
   initial begin : receiver
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (!sink_throttle) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Offers one pixel and waits for its transfer; valid stays high for a following pixel.
   task automatic send_pixel(req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Stops offering pixels and waits until every result has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (received_count != sent_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type make_pixel(logic [7:0] line, logic [7:0] col,
                                          logic [31:0] pa, logic [15:0] pb, logic bp);
      req_type p;
      p.line_index   = line;
      p.column_index = col;
      p.pixel_a      = pa;
      p.pixel_b      = pb;
      p.b_present    = bp;
      return p;
   endfunction

   // Most pixels fall inside the current window; the rest anywhere on the screen.
   function automatic req_type random_pixel();
      int unsigned width, height;
      logic [7:0]  line, col;
      logic [31:0] pa;
      width  = (shadow_cfg.capture_size == 2'd0) ? 128 : 256;
      height = (shadow_cfg.capture_size == 2'd0) ? 128 : 64 * 32'(shadow_cfg.capture_size);
      if ($urandom_range(0, 99) < 85) begin
         line = 8'($urandom_range(0, height - 1));
         col  = 8'($urandom_range(0, width - 1));
      end else begin
         line = 8'($urandom_range(0, 191));
         col  = 8'($urandom_range(0, 255));
      end
      pa = $urandom;
      if ($urandom_range(0, 3) == 0) pa[31:24] = 8'd0;
      return make_pixel(line, col, pa, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
   endfunction

   // APB write: setup cycle, then access cycle until pready.
   task automatic set_reg(logic [2:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_CAPTURE_SIZE:     shadow_cfg.capture_size = value[1:0];
         REG_DEST_BANK:        shadow_cfg.dest_bank = value[1:0];
         REG_DEST_OFFSET:      shadow_cfg.dest_offset = value[1:0];
         REG_CAPTURE_MODE:     shadow_cfg.capture_mode = value[1:0];
         REG_WEIGHT_A:         shadow_cfg.weight_a = value[4:0];
         REG_WEIGHT_B:         shadow_cfg.weight_b = value[4:0];
         REG_BANK_MAPPED_MASK: shadow_cfg.bank_mapped_mask = value[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic get_reg(logic [2:0] idx, output logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(cfg_type c);
      set_reg(REG_CAPTURE_SIZE, 32'(c.capture_size));
      set_reg(REG_DEST_BANK, 32'(c.dest_bank));
      set_reg(REG_DEST_OFFSET, 32'(c.dest_offset));
      set_reg(REG_CAPTURE_MODE, 32'(c.capture_mode));
      set_reg(REG_WEIGHT_A, 32'(c.weight_a));
      set_reg(REG_WEIGHT_B, 32'(c.weight_b));
      set_reg(REG_BANK_MAPPED_MASK, 32'(c.bank_mapped_mask));
   endtask

   function automatic cfg_type build_cfg(logic [1:0] size, logic [1:0] bank, logic [1:0] offset,
                                         logic [1:0] mode, logic [4:0] wa, logic [4:0] wb,
                                         logic [3:0] mask);
      cfg_type c;
      c.capture_size     = size;
      c.dest_bank        = bank;
      c.dest_offset      = offset;
      c.capture_mode     = mode;
      c.weight_a         = wa;
      c.weight_b         = wb;
      c.bank_mapped_mask = mask;
      return c;
   endfunction

   // Reset values first, then a written pattern, read back over the port.
   task automatic test_register_readback();
      logic [31:0] got, want;
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) apply_config(build_cfg(2'd2, 2'd1, 2'd3, 2'd1, 5'd31, 5'd17, 4'hA));
         for (int idx = int'(REG_CAPTURE_SIZE); idx <= int'(REG_BANK_MAPPED_MASK); idx++) begin
            get_reg(3'(idx), got);
            case (3'(idx))
               REG_CAPTURE_SIZE:     want = 32'(shadow_cfg.capture_size);
               REG_DEST_BANK:        want = 32'(shadow_cfg.dest_bank);
               REG_DEST_OFFSET:      want = 32'(shadow_cfg.dest_offset);
               REG_CAPTURE_MODE:     want = 32'(shadow_cfg.capture_mode);
               REG_WEIGHT_A:         want = 32'(shadow_cfg.weight_a);
               REG_WEIGHT_B:         want = 32'(shadow_cfg.weight_b);
               default:              want = 32'(shadow_cfg.bank_mapped_mask);
            endcase
            compare_field("register readback", want, got);
         end
      end
   endtask

   // Source A reduced to 5-5-5-1, at two corners of and just below a 256x64 window.
   task automatic test_source_a();
      apply_config(build_cfg(2'd1, 2'd2, 2'd3, MODE_SOURCE_A, 5'd0, 5'd0, 4'b0100));
      send_pixel(make_pixel(8'd0, 8'd0, 32'hFFFF_FFFF, 16'h0000, 1'b0));
      send_pixel(make_pixel(8'd63, 8'd255, 32'h0000_0000, 16'hFFFF, 1'b1));
      send_pixel(make_pixel(8'd31, 8'd100, 32'h013E_3E3E, 16'h1234, 1'b1));
      send_pixel(make_pixel(8'd64, 8'd0, 32'hFFFF_FFFF, 16'h0000, 1'b0));
      wait_idle();
   endtask

   // Source B passed through, and zero when it is absent.
   task automatic test_source_b();
      apply_config(build_cfg(2'd3, 2'd0, 2'd0, MODE_SOURCE_B, 5'd0, 5'd0, 4'b0001));
      send_pixel(make_pixel(8'd10, 8'd20, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
      send_pixel(make_pixel(8'd191, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
      send_pixel(make_pixel(8'd5, 8'd6, 32'h0, 16'h7FFF, 1'b1));
      wait_idle();
   endtask

   // Blend: clamped weights with saturation, one-sided weights, and rounding.
   task automatic test_blend();
      apply_config(build_cfg(2'd0, 2'd3, 2'd1, MODE_BLEND, 5'd31, 5'd31, 4'b1000));
      send_pixel(make_pixel(8'd1, 8'd1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
      send_pixel(make_pixel(8'd2, 8'd3, 32'h0010_1010, 16'h2108, 1'b1));
      wait_idle();
      apply_config(build_cfg(2'd0, 2'd3, 2'd1, MODE_BLEND_ALT, 5'd16, 5'd0, 4'b1000));
      send_pixel(make_pixel(8'd127, 8'd127, 32'h0000_3E3E, 16'hFFFF, 1'b1));
      send_pixel(make_pixel(8'd50, 8'd60, 32'h8000_2A2A, 16'h8000, 1'b1));
      wait_idle();
      apply_config(build_cfg(2'd0, 2'd3, 2'd1, MODE_BLEND, 5'd1, 5'd17, 4'b1000));
      send_pixel(make_pixel(8'd4, 8'd4, 32'hFF10_1010, 16'hFFFF, 1'b0));
      send_pixel(make_pixel(8'd4, 8'd5, 32'h0011_1111, 16'h8421, 1'b1));
      wait_idle();
   endtask

   // Window edges in the square and the tallest wide window.
   task automatic test_window();
      apply_config(build_cfg(2'd0, 2'd1, 2'd2, MODE_SOURCE_A, 5'd0, 5'd0, 4'b0010));
      send_pixel(make_pixel(8'd127, 8'd127, 32'h01AB_CDEF, 16'h0, 1'b0));
      send_pixel(make_pixel(8'd127, 8'd128, 32'h01AB_CDEF, 16'h0, 1'b0));
      send_pixel(make_pixel(8'd128, 8'd0, 32'h01AB_CDEF, 16'h0, 1'b0));
      wait_idle();
      apply_config(build_cfg(2'd3, 2'd1, 2'd3, MODE_SOURCE_A, 5'd0, 5'd0, 4'b0010));
      send_pixel(make_pixel(8'd191, 8'd255, 32'h8765_4321, 16'h0, 1'b0));
      send_pixel(make_pixel(8'd128, 8'd128, 32'h8765_4321, 16'h0, 1'b0));
      wait_idle();
   endtask

   // Destination bank not mapped: no write, all other fields zero.
   task automatic test_unmapped_bank();
      apply_config(build_cfg(2'd2, 2'd2, 2'd1, MODE_BLEND, 5'd8, 5'd8, 4'b1011));
      send_pixel(make_pixel(8'd0, 8'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
      send_pixel(make_pixel(8'd100, 8'd200, 32'h1234_5678, 16'h9ABC, 1'b1));
      wait_idle();
   endtask

   // Receiver holds off for a long stretch while pixels keep coming back to back.
   task automatic test_backpressure();
      apply_config(build_cfg(2'd1, 2'd0, 2'd2, MODE_BLEND, 5'd9, 5'd7, 4'b0001));
      sink_throttle = 1'b0;
      long_hold = 1'b1;
      repeat (40) send_pixel(random_pixel());
      wait_idle();
   endtask

   // Random configurations, extremes first, each with bursts of random pixels.
   task automatic test_random_traffic();
      cfg_type     c;
      int unsigned left, burst;
      bit          quiet;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: c = build_cfg(2'd3, 2'd3, 2'd3, MODE_BLEND_ALT, 5'd31, 5'd31, 4'hF);
            1: c = build_cfg(2'd0, 2'd0, 2'd0, MODE_SOURCE_A, 5'd0, 5'd0, 4'h1);
            default: begin
               c = build_cfg(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
                             5'($urandom), 5'($urandom), 4'($urandom));
               if ($urandom_range(0, 3) == 0) c.weight_a = 5'd16;
               if ($urandom_range(0, 3) == 0) c.weight_b = 5'd16;
               if ($urandom_range(0, 4) != 0) c.bank_mapped_mask[c.dest_bank] = 1'b1;
            end
         endcase
         apply_config(c);
         // Every third phase runs with no idling on either side.
         quiet = (phase % 3 == 2);
         sink_throttle = !quiet;
         left = PHASE_PIXELS;
         while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
               send_pixel(random_pixel());
               burst--;
               left--;
            end
            if (!quiet && left > 0 && $urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         wait_idle();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_readback();
      test_source_a();
      test_source_b();
      test_blend();
      test_window();
      test_unmapped_bank();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (10) @(posedge clock);
      if (expected_writes.size() != 0) begin
         mismatch_count++;
         $display("%0t: results missing, expected %0d more actual 0", $time,
                  expected_writes.size());
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
